// ===== hw/rtl/rcf_pkg.sv =====
package rcf_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_LOG     = 10;
    localparam int HALF_POINTS = MAX_POINTS / 2;
    localparam int QUARTER     = MAX_POINTS / 4;
    localparam int ADDR_W      = 10;
    localparam int HALF_W      = 9;
    localparam int LOG_W       = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int TW_BITS     = 16;
    localparam int TW_FRAC     = TW_BITS - 1;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 4;
    localparam int PROD_W      = DATA_W + TW_BITS + 1;
    localparam int TR_W        = PROD_W + 1 - TW_FRAC;
    localparam int SUM_W       = TR_W + 1;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic REG_LOG2 = 1'b0;
    localparam logic REG_INV  = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_REV_RD,
        S_REV_WR_I,
        S_REV_WR_R,
        S_BF_RD,
        S_BF_MUL,
        S_BF_SUM,
        S_BF_WR_E,
        S_BF_WR_O,
        S_SC_RD,
        S_SC_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WS_SAMPLE,
        WS_A,
        WS_B,
        WS_SUM,
        WS_DIFF,
        WS_SCALE
    } t_wsel;

    typedef enum logic {
        OK_ZERO,
        OK_DATA
    } t_okind;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              tw_en;
        logic [HALF_W-1:0] tw_idx;
        logic              mul_en;
        logic              sum_en;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wsel             wr_sel;
        logic              out_load;
        t_okind            out_kind;
        logic              out_status;
        logic              inverse;
        logic [LOG_W-1:0]  shift;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

    typedef logic signed [TW_BITS-1:0] t_tw_rom [HALF_POINTS];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] taylor_q30(input logic [63:0] x,
                                                      input logic want_sin);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        d;
        logic signed [63:0] acc;
        x2   = (x * x) >> 30;
        term = want_sin ? x : (64'd1 << 30);
        acc  = signed'(term);
        for (int n = 1; n <= 12; n++) begin
            d    = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = udiv64((term * x2) >> 30, d);
            if ((n & 1) == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        return acc;
    endfunction

    function automatic logic signed [TW_BITS-1:0] to_twiddle(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
        if (r > ((64'sd1 <<< TW_FRAC) - 64'sd1)) begin
            r = (64'sd1 <<< TW_FRAC) - 64'sd1;
        end
        if (r < -(64'sd1 <<< TW_FRAC)) begin
            r = -(64'sd1 <<< TW_FRAC);
        end
        return r[TW_BITS-1:0];
    endfunction

    function automatic t_tw_rom build_tw(input logic want_sin);
        t_tw_rom            rom;
        logic               flip;
        logic [63:0]        kk;
        logic [63:0]        x;
        logic signed [63:0] c;
        for (int k = 0; k < HALF_POINTS; k++) begin
            flip = k > QUARTER;
            kk   = flip ? 64'(HALF_POINTS - k) : 64'(k);
            x    = (kk * TWO_PI_Q30) >> MAX_LOG;
            if (want_sin) begin
                rom[k] = to_twiddle(taylor_q30(x, 1'b1));
            end else begin
                c      = taylor_q30(x, 1'b0);
                rom[k] = to_twiddle(flip ? -c : c);
            end
        end
        return rom;
    endfunction

endpackage

// ===== hw/rtl/rcf_datapath.sv =====
module rcf_datapath import rcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [SAMPLE_BITS-1:0]   i_sample_re,
    input  logic [SAMPLE_BITS-1:0]   i_sample_im,
    input  logic                     i_m_ready,
    output t_dp_status               o_status,
    output logic signed [DATA_W-1:0] o_res_re,
    output logic signed [DATA_W-1:0] o_res_im,
    output logic                     o_res_status
);

    localparam t_tw_rom TW_COS = build_tw(1'b0);
    localparam t_tw_rom TW_SIN = build_tw(1'b1);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
            if (v[SUM_W-1]) begin
                return {1'b1, {(DATA_W-1){1'b0}}};
            end
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    logic signed [DATA_W-1:0]  r_mem_re [MAX_POINTS];
    logic signed [DATA_W-1:0]  r_mem_im [MAX_POINTS];
    logic signed [DATA_W-1:0]  r_ra, r_ia, r_rb, r_ib;
    logic signed [TW_BITS-1:0] r_wc;
    logic signed [TW_BITS:0]   r_ws;
    logic signed [PROD_W-1:0]  r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [TR_W-1:0]    r_tr, r_ti;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_re, r_out_im;
    logic                      r_out_status;

    logic signed [PROD_W:0]    sum_tr, sum_ti;
    logic signed [DATA_W-1:0]  wr_re, wr_im;
    logic signed [DATA_W:0]    mag_re, mag_im, shf_re, shf_im, scl_re, scl_im;

    always_comb begin
        sum_tr = (PROD_W+1)'(r_p_rr) - (PROD_W+1)'(r_p_ii)
               + (PROD_W+1)'(1 << (TW_FRAC - 1));
        sum_ti = (PROD_W+1)'(r_p_ri) + (PROD_W+1)'(r_p_ir)
               + (PROD_W+1)'(1 << (TW_FRAC - 1));
        mag_re = r_ra[DATA_W-1] ? -(DATA_W+1)'(r_ra) : (DATA_W+1)'(r_ra);
        mag_im = r_ia[DATA_W-1] ? -(DATA_W+1)'(r_ia) : (DATA_W+1)'(r_ia);
        shf_re = mag_re >> i_cmd.shift;
        shf_im = mag_im >> i_cmd.shift;
        scl_re = r_ra[DATA_W-1] ? -shf_re : shf_re;
        scl_im = r_ia[DATA_W-1] ? -shf_im : shf_im;
        case (i_cmd.wr_sel)
            WS_SAMPLE: begin
                wr_re = DATA_W'(signed'(i_sample_re));
                wr_im = DATA_W'(signed'(i_sample_im));
            end
            WS_A: begin
                wr_re = r_ra;
                wr_im = r_ia;
            end
            WS_B: begin
                wr_re = r_rb;
                wr_im = r_ib;
            end
            WS_SUM: begin
                wr_re = sat32(SUM_W'(r_ra) + SUM_W'(r_tr));
                wr_im = sat32(SUM_W'(r_ia) + SUM_W'(r_ti));
            end
            WS_DIFF: begin
                wr_re = sat32(SUM_W'(r_ra) - SUM_W'(r_tr));
                wr_im = sat32(SUM_W'(r_ia) - SUM_W'(r_ti));
            end
            WS_SCALE: begin
                wr_re = scl_re[DATA_W-1:0];
                wr_im = scl_im[DATA_W-1:0];
            end
            default: begin
                wr_re = r_ra;
                wr_im = r_ia;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_re[i_cmd.wr_addr] <= wr_re;
            r_mem_im[i_cmd.wr_addr] <= wr_im;
        end
        if (i_cmd.rd_en) begin
            r_ra <= r_mem_re[i_cmd.addr_a];
            r_ia <= r_mem_im[i_cmd.addr_a];
            r_rb <= r_mem_re[i_cmd.addr_b];
            r_ib <= r_mem_im[i_cmd.addr_b];
        end
        if (i_cmd.tw_en) begin
            r_wc <= TW_COS[i_cmd.tw_idx];
            r_ws <= i_cmd.inverse ? (TW_BITS+1)'(TW_SIN[i_cmd.tw_idx])
                                  : -(TW_BITS+1)'(TW_SIN[i_cmd.tw_idx]);
        end
        if (i_cmd.mul_en) begin
            r_p_rr <= PROD_W'(r_rb * r_wc);
            r_p_ii <= PROD_W'(r_ib * r_ws);
            r_p_ri <= PROD_W'(r_rb * r_ws);
            r_p_ir <= PROD_W'(r_ib * r_wc);
        end
        if (i_cmd.sum_en) begin
            r_tr <= TR_W'(sum_tr >>> TW_FRAC);
            r_ti <= TR_W'(sum_ti >>> TW_FRAC);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_kind == OK_DATA) begin
                r_out_re <= r_ra;
                r_out_im <= r_ia;
            end else begin
                r_out_re <= '0;
                r_out_im <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_res_re           = r_out_re;
    assign o_res_im           = r_out_im;
    assign o_res_status       = r_out_status;

endmodule

// ===== hw/rtl/rcf_ctrl.sv =====
module rcf_ctrl import rcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic [1:0]        i_command,
    input  logic [ADDR_W-1:0] i_index,
    input  logic              i_m_ready,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [HALF_W-1:0] r_b, n_b;
    logic [LOG_W-1:0]  r_s, n_s;
    logic [LOG_W-1:0]  r_log2;
    logic              r_inv;

    logic [LOG_W-1:0]  eff_l;
    logic [ADDR_W-1:0] n_mask;
    logic [HALF_W-1:0] half_mask;
    logic [ADDR_W-1:0] rev_full, rev_i, len, e_addr, o_addr;
    logic              oor, accept;

    always_comb begin
        eff_l = r_log2;
        if (eff_l < LOG_W'(1)) begin
            eff_l = LOG_W'(1);
        end
        if (eff_l > LOG_W'(MAX_LOG)) begin
            eff_l = LOG_W'(MAX_LOG);
        end
        n_mask    = ADDR_W'(((ADDR_W+1)'(1) << eff_l) - (ADDR_W+1)'(1));
        half_mask = HALF_W'(n_mask >> 1);
        for (int k = 0; k < ADDR_W; k++) begin
            rev_full[k] = r_i[ADDR_W-1-k];
        end
        rev_i  = rev_full >> (LOG_W'(ADDR_W) - eff_l);
        len    = ADDR_W'(1) << r_s;
        e_addr = ((ADDR_W'(r_b) >> r_s) << (r_s + LOG_W'(1))) | (ADDR_W'(r_b) & (len - 1'b1));
        o_addr = e_addr | len;
        oor    = (i_index >> eff_l) != '0;
    end

    assign o_s_ready = (r_state == S_IDLE) && (!i_status.out_valid || i_m_ready);
    assign accept    = i_s_valid && o_s_ready;

    always_comb begin
        n_state          = r_state;
        n_i              = r_i;
        n_b              = r_b;
        n_s              = r_s;
        o_cmd            = '0;
        o_cmd.wr_sel     = WS_SAMPLE;
        o_cmd.out_kind   = OK_ZERO;
        o_cmd.inverse    = r_inv;
        o_cmd.shift      = eff_l;
        o_cmd.tw_idx     = HALF_W'((ADDR_W'(r_b) & (len - 1'b1))
                                   << (LOG_W'(MAX_LOG - 1) - r_s));
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            o_cmd.wr_en      = !oor;
                            o_cmd.wr_addr    = i_index;
                            o_cmd.wr_sel     = WS_SAMPLE;
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = oor;
                        end
                        CMD_READ: begin
                            if (oor) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = 1'b1;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.addr_a = i_index;
                                n_state      = S_READ;
                            end
                        end
                        CMD_RUN: begin
                            n_i     = '0;
                            n_state = S_REV_RD;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_kind = OK_DATA;
                n_state        = S_IDLE;
            end
            S_REV_RD, S_REV_WR_R: begin
                o_cmd.addr_a  = r_i;
                o_cmd.addr_b  = rev_i;
                o_cmd.wr_addr = rev_i;
                o_cmd.wr_sel  = WS_A;
                o_cmd.wr_en   = (r_state == S_REV_WR_R);
                if ((r_state == S_REV_RD) && (r_i < rev_i)) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_REV_WR_I;
                end else if (r_i == n_mask) begin
                    n_b     = '0;
                    n_s     = '0;
                    n_state = S_BF_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_REV_RD;
                end
            end
            S_REV_WR_I: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.wr_sel  = WS_B;
                n_state       = S_REV_WR_R;
            end
            S_BF_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.tw_en  = 1'b1;
                o_cmd.addr_a = e_addr;
                o_cmd.addr_b = o_addr;
                n_state      = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_BF_SUM;
            end
            S_BF_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_BF_WR_E;
            end
            S_BF_WR_E: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = e_addr;
                o_cmd.wr_sel  = WS_SUM;
                n_state       = S_BF_WR_O;
            end
            S_BF_WR_O: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = o_addr;
                o_cmd.wr_sel  = WS_DIFF;
                n_state       = S_BF_RD;
                if (r_b == half_mask) begin
                    n_b = '0;
                    if (r_s == eff_l - 1'b1) begin
                        n_i     = '0;
                        n_state = r_inv ? S_SC_RD : S_DONE;
                    end else begin
                        n_s = r_s + 1'b1;
                    end
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            S_SC_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr_a = r_i;
                n_state      = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.wr_sel  = WS_SCALE;
                if (r_i == n_mask) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_b     <= '0;
            r_s     <= '0;
            r_log2  <= LOG_W'(MAX_LOG);
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_b     <= n_b;
            r_s     <= n_s;
            if (i_cfg_we && (i_cfg_idx == REG_LOG2)) begin
                r_log2 <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_INV)) begin
                r_inv <= i_cfg_data[0];
            end
        end
    end

    a_ready_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_ready |-> (!i_status.out_valid || i_m_ready))
        else $error("request taken while result slot is busy");

    a_read_goes_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_cmd'(i_command) == CMD_READ) && !oor) |=> (r_state == S_READ))
        else $error("in-range read did not fetch");

    a_bf_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_RD) |-> ((r_b & ~half_mask) == '0))
        else $error("butterfly counter beyond N/2");

    a_bf_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_WR_O) |=>
            (r_state == S_BF_RD || r_state == S_SC_RD || r_state == S_DONE))
        else $error("butterfly sequence broken");

endmodule

// ===== hw/rtl/radix2_complex_fft_top.sv =====
// In-place radix-2 decimation-in-time FFT over up to 1024 complex points held in two
// 32-bit stores. Each request carries a command: write a sample at an index, read a
// bin at an index (result from a registered memory read), run the transform, or a
// no-op. A run does a bit-reversal pass, then (N/2)*log2(N) butterflies, then a divide
// by N pass in inverse mode, then posts the result; the point memory has a single
// write port and each butterfly is a multiply/round/add sequence.
// Every request returns one result; status flags an index at or beyond N. Load all N
// points before running; the user must write configuration only while the block is
// idle, as the block itself does not enforce it.
module radix2_complex_fft_top import rcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // command[1:0], index[11:2], sample_real[27:12], sample_imag[43:28]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_real[31:0], result_imag[63:32]
    output logic [63:0] o_m_axis_tdata,
    // status[0]
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd                  cmd;
    t_dp_status               dp_status;
    logic signed [DATA_W-1:0] res_re, res_im;
    logic                     res_status;

    rcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .i_command  (i_s_axis_tdata[1:0]),
        .i_index    (i_s_axis_tdata[11:2]),
        .i_m_ready  (i_m_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    rcf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample_re  (i_s_axis_tdata[27:12]),
        .i_sample_im  (i_s_axis_tdata[43:28]),
        .i_m_ready    (i_m_axis_tready),
        .o_status     (dp_status),
        .o_res_re     (res_re),
        .o_res_im     (res_im),
        .o_res_status (res_status)
    );

    assign o_m_axis_tvalid = dp_status.out_valid;
    assign o_m_axis_tdata  = {res_im, res_re};
    assign o_m_axis_tuser  = res_status;

endmodule
